// File: rtl/core/sba_pkg.sv
// Shared buffer admission package: field widths, register indexes, reset values,
// and the command/status/config structs shared by the controller, datapath and top.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

  // Fixed payload and register widths
  localparam int PORT_W     = 3;
  localparam int SIZE_W     = 14;
  localparam int FE_W       = 3;
  localparam int LIMIT_W    = 24;
  localparam int ALPHA_W    = 16;
  localparam int HEAD_W     = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = ALPHA_W + LIMIT_W;   // alpha * free shared bytes
  localparam int LIM_W      = PROD_W + HEAD_W;     // alpha * free * headroom

  // Operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Feature enable bit positions
  localparam int FE_SHARED   = 0;
  localparam int FE_POOL_ECN = 1;
  localparam int FE_BUF_ECN  = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FEATURE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHARED_LIM  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESERVE_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STATIC_LIM  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_MARK   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_MARK   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEADROOM    = 3'd7;

  // Register reset values
  localparam logic [FE_W-1:0]    RST_FEATURE     = 3'd0;
  localparam logic [LIMIT_W-1:0] RST_SHARED_LIM  = 24'd0;
  localparam logic [LIMIT_W-1:0] RST_RESERVE_LIM = 24'd262144;
  localparam logic [ALPHA_W-1:0] RST_ALPHA       = 16'd256;
  localparam logic [LIMIT_W-1:0] RST_STATIC_LIM  = 24'd16777215;
  localparam logic [LIMIT_W-1:0] RST_PORT_MARK   = 24'd540000;
  localparam logic [LIMIT_W-1:0] RST_POOL_MARK   = 24'd0;
  localparam logic [HEAD_W-1:0]  RST_HEADROOM    = 9'd230;

  typedef struct packed {
    logic [FE_W-1:0]    feature_enables;
    logic [LIMIT_W-1:0] shared_limit_bytes;
    logic [LIMIT_W-1:0] reserve_limit_bytes;
    logic [ALPHA_W-1:0] alpha_q8;
    logic [LIMIT_W-1:0] static_limit_bytes;
    logic [LIMIT_W-1:0] port_mark_thresh_bytes;
    logic [LIMIT_W-1:0] pool_mark_thresh_bytes;
    logic [HEAD_W-1:0]  headroom_q8;
  } sba_cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // capture the input beat
    logic rd_port;   // read the port's counters
    logic mul_free;  // alpha * free shared bytes
    logic dec;       // decide and write back
    logic mul_lim;   // scale by headroom
    logic scan_rd;   // read next port occupancy
    logic scan_cmp;  // compare occupancy read last cycle
    logic fin;       // issue the dequeue result
  } sba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_deq;
    logic scan_en;
    logic scan_last;
  } sba_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/sba_ctrl.sv
// Shared buffer admission controller: sequences read, decide, threshold
// multiply and the port occupancy scan. Depends on sba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sba_ctrl
  import sba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire sba_stat_t stat,
  output logic           busy,
  output sba_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DEC  = 3'd2;
  localparam logic [2:0] S_MUL1 = 3'd3;
  localparam logic [2:0] S_MUL2 = 3'd4;
  localparam logic [2:0] S_SCAN = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       scan_cmp_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) state_nxt = S_RD;
      S_RD:   state_nxt = S_DEC;
      S_DEC: begin
        if (!stat.is_deq) state_nxt = S_IDLE;
        else if (stat.scan_en) state_nxt = S_MUL1;
        else state_nxt = S_FIN;
      end
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_SCAN;
      S_SCAN: if (stat.scan_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      scan_cmp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cmp_r <= (state_r == S_SCAN);
    end
  end

  assign busy         = (state_r != S_IDLE);
  assign cmd.load     = (state_r == S_IDLE) && start;
  assign cmd.rd_port  = (state_r == S_RD);
  assign cmd.mul_free = (state_r == S_RD) || (state_r == S_MUL1);
  assign cmd.dec      = (state_r == S_DEC);
  assign cmd.mul_lim  = (state_r == S_MUL2);
  assign cmd.scan_rd  = (state_r == S_SCAN);
  assign cmd.scan_cmp = scan_cmp_r;
  assign cmd.fin      = (state_r == S_FIN);

endmodule

`default_nettype wire

// File: rtl/core/sba_dp.sv
// Shared buffer admission datapath: per-port occupancy and reserve memories,
// shared pool counter, threshold multipliers, result registers. Depends on sba_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sba_dp
  import sba_pkg::*;
#(
  parameter int NUM_PORTS        = 8,
  parameter int BYTE_COUNT_WIDTH = 24
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sba_cmd_t          cmd,
  input  wire sba_cfg_t          cfg,
  input  wire logic              in_operation,
  input  wire logic [PORT_W-1:0] in_port,
  input  wire logic [SIZE_W-1:0] in_pkt_size,
  input  wire logic              in_ect,
  input  wire logic              in_from_reserve,
  output sba_stat_t              stat,
  output logic                   out_strobe,
  output logic                   out_admitted,
  output logic                   out_reserve_pool,
  output logic                   out_drop_before_mark,
  output logic                   out_ce_mark
);

  localparam int BCW  = BYTE_COUNT_WIDTH;
  localparam int CW   = BCW + 1;
  localparam int PIW  = $clog2(NUM_PORTS);
  localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam int FW   = (BCW > LIMIT_W) ? BCW : LIMIT_W;
  localparam int DW   = (CW + 8 > PROD_W) ? CW + 8 : PROD_W;
  localparam int SW   = (BCW + 16 > LIM_W) ? BCW + 16 : LIM_W;

  function automatic logic [BCW-1:0] sat_up(input logic [CW-1:0] s);
    return s[CW-1] ? {BCW{1'b1}} : s[BCW-1:0];
  endfunction

  function automatic logic [BCW-1:0] sat_dn(input logic [BCW-1:0] a,
                                            input logic [BCW-1:0] b);
    return (a > b) ? a - b : '0;
  endfunction

  // Captured input beat
  logic              op_r;
  logic [PORT_W-1:0] port_r;
  logic [SIZE_W-1:0] size_r;
  logic              ect_r;
  logic              from_res_r;

  // Storage
  logic [BCW-1:0]       pq_mem  [NUM_PORTS];
  logic [BCW-1:0]       res_mem [NUM_PORTS];
  logic [NUM_PORTS-1:0] pq_vld_r, res_vld_r;
  logic [BCW-1:0]       pq_rd_r, res_rd_r;
  logic                 pq_rv_r, res_rv_r;
  logic [BCW-1:0]       shared_used_r;

  logic [PROD_W-1:0]    prod_r;
  logic [LIM_W-1:0]     lim_r;
  logic [PIW-1:0]       scan_idx_r;
  logic                 any_r;
  logic                 port_mark_r;
  logic                 out_strobe_r, out_admitted_r, out_reserve_r, out_dbm_r, out_ce_r;

  logic             in_range, is_deq, shared;
  logic [PIW-1:0]   port_idx, rd_idx;
  logic [BCW-1:0]   pq_val, res_val, size_b;
  logic [CW-1:0]    len, res_sum;
  logic             res_ok, dyn_ok, stat_ok, admit, dbm;
  logic [BCW-1:0]   pq_wdata, res_wdata;
  logic             pq_we, res_we;
  logic [FW-1:0]    used_x, slim_x, free_x;
  logic [LIMIT_W-1:0] free24;
  logic             cmp_hit, pool_mark;

  assign in_range = (32'(port_r) < 32'(NUM_PORTS));
  assign is_deq   = (op_r == OP_DEQ);
  assign shared   = cfg.feature_enables[FE_SHARED];
  assign port_idx = in_range ? PIW'(port_r) : '0;
  assign rd_idx   = cmd.scan_rd ? scan_idx_r : port_idx;

  assign pq_val  = pq_rv_r  ? pq_rd_r  : '0;
  assign res_val = res_rv_r ? res_rd_r : '0;
  assign size_b  = BCW'(size_r);

  // Enqueue decision
  assign len     = {1'b0, pq_val}  + CW'(size_r);
  assign res_sum = {1'b0, res_val} + CW'(size_r);
  assign res_ok  = shared && (CMPW'(res_sum) <= CMPW'(cfg.reserve_limit_bytes));
  assign dyn_ok  = shared && !res_ok && (DW'({len, 8'd0}) <= DW'(prod_r));
  assign stat_ok = !shared && (CMPW'(len) <= CMPW'(cfg.static_limit_bytes));
  assign admit   = in_range && (res_ok || dyn_ok || stat_ok);
  assign dbm     = in_range && !admit &&
                   (CMPW'(len) < CMPW'(cfg.port_mark_thresh_bytes));

  // Write-back values
  assign pq_wdata  = is_deq ? sat_dn(pq_val, size_b)  : sat_up(len);
  assign res_wdata = is_deq ? sat_dn(res_val, size_b) : sat_up(res_sum);
  assign pq_we     = cmd.dec && in_range && (is_deq || admit);
  assign res_we    = cmd.dec && in_range && shared && (is_deq ? from_res_r : res_ok);

  // Free shared bytes, never above the shared limit
  assign used_x = FW'(shared_used_r);
  assign slim_x = FW'(cfg.shared_limit_bytes);
  assign free_x = (slim_x > used_x) ? slim_x - used_x : '0;
  assign free24 = free_x[LIMIT_W-1:0];

  assign cmp_hit   = (SW'({pq_val, 16'd0}) > SW'(lim_r));
  assign pool_mark = ect_r && shared && cfg.feature_enables[FE_POOL_ECN] &&
                     (FW'(shared_used_r) > FW'(cfg.pool_mark_thresh_bytes));

  assign stat.is_deq    = is_deq;
  assign stat.scan_en   = is_deq && in_range && ect_r && shared &&
                          cfg.feature_enables[FE_BUF_ECN];
  assign stat.scan_last = (scan_idx_r == PIW'(NUM_PORTS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_operation;
      port_r     <= in_port;
      size_r     <= in_pkt_size;
      ect_r      <= in_ect;
      from_res_r <= in_from_reserve;
    end
  end

  // Memories: one write and one registered read each
  always_ff @(posedge clk) begin
    if (pq_we) pq_mem[port_idx] <= pq_wdata;
    if (res_we) res_mem[port_idx] <= res_wdata;
    if (cmd.rd_port || cmd.scan_rd) begin
      pq_rd_r <= pq_mem[rd_idx];
      pq_rv_r <= pq_vld_r[rd_idx];
    end
    if (cmd.rd_port) begin
      res_rd_r <= res_mem[port_idx];
      res_rv_r <= res_vld_r[port_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pq_vld_r      <= '0;
      res_vld_r     <= '0;
      shared_used_r <= '0;
      out_strobe_r  <= 1'b0;
    end else begin
      if (pq_we) pq_vld_r[port_idx] <= 1'b1;
      if (res_we) res_vld_r[port_idx] <= 1'b1;
      if (cmd.dec && in_range) begin
        if (!is_deq && dyn_ok)
          shared_used_r <= sat_up({1'b0, shared_used_r} + CW'(size_r));
        else if (is_deq && shared && !from_res_r)
          shared_used_r <= sat_dn(shared_used_r, size_b);
      end
      out_strobe_r <= (cmd.dec && !is_deq) || cmd.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_free) prod_r <= PROD_W'(cfg.alpha_q8) * PROD_W'(free24);
    if (cmd.mul_lim) lim_r <= LIM_W'(prod_r) * LIM_W'(cfg.headroom_q8);

    if (cmd.dec) begin
      scan_idx_r  <= '0;
      any_r       <= 1'b0;
      port_mark_r <= ect_r && in_range &&
                     ((CMPW'(pq_val) > CMPW'(cfg.port_mark_thresh_bytes)) ||
                      (CMPW'(size_r) > CMPW'(cfg.port_mark_thresh_bytes)));
    end else begin
      if (cmd.scan_rd) scan_idx_r <= scan_idx_r + PIW'(1);
      if (cmd.scan_cmp) any_r <= any_r || cmp_hit;
    end

    if (cmd.dec && !is_deq) begin
      out_admitted_r <= admit;
      out_reserve_r  <= in_range && res_ok;
      out_dbm_r      <= dbm;
      out_ce_r       <= 1'b0;
    end else if (cmd.fin) begin
      out_admitted_r <= 1'b1;
      out_reserve_r  <= 1'b0;
      out_dbm_r      <= 1'b0;
      out_ce_r       <= in_range &&
                        (port_mark_r || pool_mark || any_r || (cmd.scan_cmp && cmp_hit));
    end
  end

  assign out_strobe           = out_strobe_r;
  assign out_admitted         = out_admitted_r;
  assign out_reserve_pool     = out_reserve_r;
  assign out_drop_before_mark = out_dbm_r;
  assign out_ce_mark          = out_ce_r;

endmodule

`default_nettype wire

// File: rtl/core/shared_buffer_admission_ecn.sv
// Shared buffer admission control with ECN marking: top level holding the
// configuration registers, controller and datapath. Depends on sba_pkg, sba_ctrl, sba_dp.
`timescale 1ns / 1ps
`default_nettype none

// Admission and ECN marking for one switch buffer. Pulse start while busy is low to
// hand over one enqueue or dequeue beat; the answer appears for exactly one cycle
// with out_strobe high and cannot be held off, so capture it on that cycle. An
// enqueue runs a read step and then a decide step, and its result strobe is
// registered from the decide step. A dequeue runs read, decide and a finish
// step; when buffer-aware marking is active for an ECN-capable packet in shared
// mode it also scans every port's occupancy, one port per cycle, through the
// single read port of the occupancy memory, after the alpha and headroom
// threshold multiplies. Configuration writes must only be issued while busy is
// low and no strobe is pending.
module shared_buffer_admission_ecn
  import sba_pkg::*;
#(
  parameter int NUM_PORTS        = 8,
  parameter int BYTE_COUNT_WIDTH = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // command channel
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic                  in_operation,
  input  wire logic [PORT_W-1:0]     in_port,
  input  wire logic [SIZE_W-1:0]     in_pkt_size,
  input  wire logic                  in_ect,
  input  wire logic                  in_from_reserve,
  // result channel
  output logic                       out_strobe,
  output logic                       out_admitted,
  output logic                       out_reserve_pool,
  output logic                       out_drop_before_mark,
  output logic                       out_ce_mark,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  sba_cfg_t  cfg_r;
  sba_cmd_t  cmd;
  sba_stat_t stat;

  // Configuration registers: take the low bits of the write data for narrow fields.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.feature_enables        <= RST_FEATURE;
      cfg_r.shared_limit_bytes     <= RST_SHARED_LIM;
      cfg_r.reserve_limit_bytes    <= RST_RESERVE_LIM;
      cfg_r.alpha_q8               <= RST_ALPHA;
      cfg_r.static_limit_bytes     <= RST_STATIC_LIM;
      cfg_r.port_mark_thresh_bytes <= RST_PORT_MARK;
      cfg_r.pool_mark_thresh_bytes <= RST_POOL_MARK;
      cfg_r.headroom_q8            <= RST_HEADROOM;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FEATURE:     cfg_r.feature_enables        <= cfg_wdata[FE_W-1:0];
        REG_SHARED_LIM:  cfg_r.shared_limit_bytes     <= cfg_wdata[LIMIT_W-1:0];
        REG_RESERVE_LIM: cfg_r.reserve_limit_bytes    <= cfg_wdata[LIMIT_W-1:0];
        REG_ALPHA:       cfg_r.alpha_q8               <= cfg_wdata[ALPHA_W-1:0];
        REG_STATIC_LIM:  cfg_r.static_limit_bytes     <= cfg_wdata[LIMIT_W-1:0];
        REG_PORT_MARK:   cfg_r.port_mark_thresh_bytes <= cfg_wdata[LIMIT_W-1:0];
        REG_POOL_MARK:   cfg_r.pool_mark_thresh_bytes <= cfg_wdata[LIMIT_W-1:0];
        REG_HEADROOM:    cfg_r.headroom_q8            <= cfg_wdata[HEAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: drives the datapath one step per cycle.
  sba_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Counters, thresholds and result registers.
  sba_dp #(
    .NUM_PORTS        (NUM_PORTS),
    .BYTE_COUNT_WIDTH (BYTE_COUNT_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg                  (cfg_r),
    .in_operation         (in_operation),
    .in_port              (in_port),
    .in_pkt_size          (in_pkt_size),
    .in_ect               (in_ect),
    .in_from_reserve      (in_from_reserve),
    .stat                 (stat),
    .out_strobe           (out_strobe),
    .out_admitted         (out_admitted),
    .out_reserve_pool     (out_reserve_pool),
    .out_drop_before_mark (out_drop_before_mark),
    .out_ce_mark          (out_ce_mark)
  );

  // An accepted beat always makes the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not start work");

  // Going idle always coincides with a result strobe.
  a_idle_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("block went idle without a result");

  // A strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  // Reserve admission and CE marks only come with an admitted beat.
  a_flags_admit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_reserve_pool || out_ce_mark)) |-> out_admitted)
    else $error("reserve or CE flag on a dropped packet");

  // Drop-before-mark only on a dropped packet.
  a_dbm_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_drop_before_mark) |-> !out_admitted)
    else $error("drop-before-mark on an admitted packet");

endmodule

`default_nettype wire
